### src/pmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types and constants for the PID motor drive with deadband.
// ----------------------------------------------------------------------------
package pmd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GAIN_W    = 32;
  localparam int POS_W     = 16;
  localparam int ERR_W     = POS_W + 1;
  localparam int DRIVE_W   = 13;
  localparam int DUTY_W    = 12;
  localparam int DUTY_BITS = 12;
  localparam int FIELD_DUTY_MAX = 4095;
  localparam int DUTY_LIM  = (1 << DUTY_BITS) - 1;
  localparam logic [DUTY_W-1:0] DUTY_MAX =
      DUTY_W'((DUTY_LIM > FIELD_DUTY_MAX) ? FIELD_DUTY_MAX : DUTY_LIM);
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_DEAD_BAND  = 3'd3,
    REG_LIMIT_LOW  = 3'd4,
    REG_LIMIT_HIGH = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  prop_gain;
    logic signed [GAIN_W-1:0]  integ_gain_times_period;
    logic signed [GAIN_W-1:0]  deriv_gain_over_period;
    logic        [15:0]        dead_band;
    logic signed [DRIVE_W-1:0] limit_low;
    logic        [DUTY_W-1:0]  limit_high;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] target;
    logic signed [POS_W-1:0] measured;
  } in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic        [DUTY_W-1:0]  duty_forward;
    logic        [DUTY_W-1:0]  duty_reverse;
    logic                      in_dead_band;
  } out_t;

endpackage

### src/pid_motor_drive_with_deadband_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_motor_drive_with_deadband_top
// Discrete PID position loop with deadband, clamp and PWM duty split.
// ----------------------------------------------------------------------------
// A request passes the stage 1, stage 2 and output registers before its result is valid.
// Throughput: one request per cycle; stalls only when the output backs up.
// Stages: input register, gain multipliers, integral update, clamp and duty split, output register.
// Reset clears integral, previous error and pipeline, and loads default config.
module pid_motor_drive_with_deadband_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pmd_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pmd_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import pmd_pkg::*;

  localparam int KE_W    = GAIN_W + ERR_W;
  localparam int KD_W    = GAIN_W + ERR_W + 1;
  localparam int PSUM_W  = KD_W + 1;
  localparam int INTEG_W = DUTY_W + 1 + FRAC_BITS;
  localparam int ACC_W   = KE_W + 1;
  localparam int SUM_W   = PSUM_W + 1;
  localparam int LIM_W   = DRIVE_W + FRAC_BITS;

  function automatic logic signed [SUM_W-1:0] clamp_q(
    input logic signed [SUM_W-1:0] v,
    input logic signed [SUM_W-1:0] hi,
    input logic signed [SUM_W-1:0] lo
  );
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end
    return r;
  endfunction

  cfg_t cfg;

  pmd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pipeline control
  logic s1_valid, s2_valid;
  logic s1_load, s2_load, out_load;

  assign out_load = !out_valid || out_ready;
  assign s2_load  = !s2_valid || out_load;
  assign s1_load  = !s1_valid || s2_load;
  assign in_ready = s1_load;

  // state
  logic signed [INTEG_W-1:0] integ;
  logic signed [ERR_W-1:0]   prev_err;

  // stage 1: error, deadband, products
  in_t                      s1_item;
  logic signed [ERR_W-1:0]  err;
  logic        [ERR_W-1:0]  mag;
  logic signed [ERR_W:0]    diff;
  logic                     dead;
  logic signed [KE_W-1:0]   kp_e;
  logic signed [KE_W-1:0]   ki_e;
  logic signed [KD_W-1:0]   kd_d;

  always_comb begin
    err  = ERR_W'(s1_item.target) - ERR_W'(s1_item.measured);
    mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    dead = mag < ERR_W'(cfg.dead_band);
    diff = (ERR_W+1)'(err) - (ERR_W+1)'(prev_err);
    kp_e = KE_W'(cfg.prop_gain) * KE_W'(err);
    ki_e = KE_W'(cfg.integ_gain_times_period) * KE_W'(err);
    kd_d = KD_W'(cfg.deriv_gain_over_period) * KD_W'(diff);
  end

  // stage 2: integral update, output sum, clamps, duty split
  logic                      s2_dead;
  logic signed [KE_W-1:0]    s2_ki_e;
  logic signed [PSUM_W-1:0]  s2_p_sum;
  logic signed [ACC_W-1:0]   integ_acc;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   sum_c;
  logic signed [SUM_W-1:0]   integ_c;
  logic signed [SUM_W-1:0]   lim_hi;
  logic signed [SUM_W-1:0]   lim_lo;
  logic signed [SUM_W-1:0]   sum_q;
  logic                      round_up;
  logic signed [DRIVE_W-1:0] drive_val;
  logic        [DUTY_W-1:0]  fwd_mag;
  logic        [DRIVE_W-1:0] rev_mag;
  logic signed [INTEG_W-1:0] integ_next;
  out_t                      result;

  always_comb begin
    lim_hi     = SUM_W'($signed({1'b0, cfg.limit_high, {FRAC_BITS{1'b0}}}));
    lim_lo     = SUM_W'($signed(LIM_W'({cfg.limit_low, {FRAC_BITS{1'b0}}})));
    integ_acc  = ACC_W'(integ) + ACC_W'(s2_ki_e);
    sum        = SUM_W'(s2_p_sum) + SUM_W'(integ_acc);
    sum_c      = clamp_q(sum, lim_hi, lim_lo);
    integ_c    = clamp_q(SUM_W'(integ_acc), lim_hi, lim_lo);
    integ_next = INTEG_W'(integ_c);
    // truncate toward zero
    sum_q      = sum_c >>> FRAC_BITS;
    round_up   = sum_c[SUM_W-1] && (sum_c[FRAC_BITS-1:0] != '0);
    drive_val  = DRIVE_W'(sum_q) + DRIVE_W'(round_up);
    fwd_mag    = drive_val[DUTY_W-1:0];
    // unsigned magnitude, so the most negative drive reads as 4096
    rev_mag    = DRIVE_W'(-drive_val);
    result     = '0;
    if (s2_dead) begin
      result.in_dead_band = 1'b1;
    end else begin
      result.drive = drive_val;
      if (drive_val > 0) begin
        result.duty_forward = (fwd_mag > DUTY_MAX) ? DUTY_MAX : fwd_mag;
      end
      if (drive_val < 0) begin
        result.duty_reverse = (rev_mag > DRIVE_W'(DUTY_MAX)) ? DUTY_MAX :
                              rev_mag[DUTY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      integ     <= '0;
      prev_err  <= '0;
    end else begin
      if (s1_load) begin
        s1_valid <= in_valid;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
      if (out_load) begin
        out_valid <= s2_valid;
      end
      if (s1_valid && s2_load) begin
        prev_err <= dead ? '0 : err;
      end
      if (s2_valid && out_load && !s2_dead) begin
        integ <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_item <= in_data;
    end
    if (s2_load && s1_valid) begin
      s2_dead  <= dead;
      s2_ki_e  <= ki_e;
      s2_p_sum <= PSUM_W'(kp_e) + PSUM_W'(kd_d);
    end
    if (out_load && s2_valid) begin
      out_data <= result;
    end
  end

  // checks
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s2_valid && out_valid)
    else $error("input stalled with a free stage");

  a_dead_keeps_integ: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_dead && out_load |=> $stable(integ))
    else $error("deadband request changed the integral");

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_load |=> s2_valid && $stable(s2_p_sum) && $stable(s2_ki_e))
    else $error("stalled stage lost its request");

  a_duty_matches_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive > 0 |->
      out_data.duty_forward == out_data.drive[DUTY_W-1:0] && out_data.duty_reverse == '0)
    else $error("forward duty disagrees with drive");

  a_dead_zero_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.in_dead_band |->
      out_data.drive == '0 && out_data.duty_forward == '0 && out_data.duty_reverse == '0)
    else $error("deadband result not zero");

endmodule

### src/pmd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_cfg_regs
// Configuration register file: gains, deadband and clamp limits.
// ----------------------------------------------------------------------------
module pmd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output pmd_pkg::cfg_t                 cfg
);
  import pmd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain               <= 32'sd327680;
      cfg.integ_gain_times_period <= 32'sd49152000;
      cfg.deriv_gain_over_period  <= 32'sd4;
      cfg.dead_band               <= 16'd10;
      cfg.limit_low               <= -13'sd950;
      cfg.limit_high              <= 12'd950;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:  cfg.prop_gain               <= cfg_data;
        REG_INTEG_GAIN: cfg.integ_gain_times_period <= cfg_data;
        REG_DERIV_GAIN: cfg.deriv_gain_over_period  <= cfg_data;
        REG_DEAD_BAND:  cfg.dead_band               <= cfg_data[15:0];
        REG_LIMIT_LOW:  cfg.limit_low               <= cfg_data[DRIVE_W-1:0];
        REG_LIMIT_HIGH: cfg.limit_high              <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### sim/pid_motor_drive_with_deadband_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_motor_drive_with_deadband_top_tb
// Checks the PID drive loop tick by tick against an in-bench model of the
// error, deadband, integral, clamp and duty split. Directed ticks cover
// deadband edges, extreme gains and limits, crossed limits and unmapped
// register writes. Random phases with new settings follow, with bursty
// requests and a stalling result side.
// ----------------------------------------------------------------------------
module pid_motor_drive_with_deadband_top_tb;
  import pmd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;
  localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  pid_motor_drive_with_deadband_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // loop model state and settings
  longint gain_p     = 327680;
  longint gain_i     = 49152000;
  longint gain_d     = 4;
  longint band_width = 10;
  longint clamp_lo   = -950;
  longint clamp_hi   = 950;
  longint integ_sum  = 0;
  longint prev_error = 0;

  out_t drive_expected_q[$];
  int   mismatch_count = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;
  int   rx_left = 0;
  int   rx_mode = 0;

  function automatic longint clamp_to_limits(input longint v);
    if (v > clamp_hi * FRAC_ONE) return clamp_hi * FRAC_ONE;
    if (v < clamp_lo * FRAC_ONE) return clamp_lo * FRAC_ONE;
    return v;
  endfunction

  function automatic logic [DUTY_W-1:0] duty_sat(input longint mag);
    if (mag > longint'(DUTY_MAX)) return DUTY_MAX;
    return mag[DUTY_W-1:0];
  endfunction

  function automatic out_t predict_drive(input in_t req);
    longint err;
    longint mag;
    longint sum;
    longint drv;
    out_t   res;
    err = longint'($signed(req.target)) - longint'($signed(req.measured));
    mag = (err < 0) ? -err : err;
    res = '0;
    if (mag < band_width) begin
      prev_error = 0;
      res.in_dead_band = 1'b1;
      return res;
    end
    integ_sum = integ_sum + gain_i * err;
    sum = gain_p * err + integ_sum + gain_d * (err - prev_error);
    sum = clamp_to_limits(sum);
    integ_sum = clamp_to_limits(integ_sum);
    prev_error = err;
    drv = sum / FRAC_ONE;
    res.drive = drv[DRIVE_W-1:0];
    if (drv > 0) res.duty_forward = duty_sat(drv);
    if (drv < 0) res.duty_reverse = duty_sat(-drv);
    return res;
  endfunction

  // result side stall pattern: free running, random, or held off
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(1, 40);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (drive_expected_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none actual %p", $time, out_data);
      end else begin
        want = drive_expected_q.pop_front();
        if (out_data.drive !== want.drive) begin
          mismatch_count++;
          $display("%0t: drive expected %0d actual %0d", $time, want.drive, out_data.drive);
        end
        if (out_data.duty_forward !== want.duty_forward) begin
          mismatch_count++;
          $display("%0t: duty_forward expected %0d actual %0d", $time,
                   want.duty_forward, out_data.duty_forward);
        end
        if (out_data.duty_reverse !== want.duty_reverse) begin
          mismatch_count++;
          $display("%0t: duty_reverse expected %0d actual %0d", $time,
                   want.duty_reverse, out_data.duty_reverse);
        end
        if (out_data.in_dead_band !== want.in_dead_band) begin
          mismatch_count++;
          $display("%0t: in_dead_band expected %0d actual %0d", $time,
                   want.in_dead_band, out_data.in_dead_band);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL pid_motor_drive_with_deadband_top");
    $finish;
  end

  task automatic wait_drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (drive_expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_tick(input logic [15:0] tgt, input logic [15:0] meas);
    in_t req;
    int  gap;
    req.target = tgt;
    req.measured = meas;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    drive_expected_q.push_back(predict_drive(req));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PROP_GAIN:  gain_p = longint'($signed(val));
      REG_INTEG_GAIN: gain_i = longint'($signed(val));
      REG_DERIV_GAIN: gain_d = longint'($signed(val));
      REG_DEAD_BAND:  band_width = longint'(val[15:0]);
      REG_LIMIT_LOW:  clamp_lo = longint'($signed(val[DRIVE_W-1:0]));
      REG_LIMIT_HIGH: clamp_hi = longint'(val[DUTY_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic send_random_tick();
    logic [15:0] meas;
    int          span;
    meas = 16'($urandom);
    span = int'(band_width) + 2;
    case ($urandom_range(0, 9))
      0, 1: send_tick(16'($urandom), meas);
      2, 3, 4: send_tick(meas + 16'(int'($urandom_range(0, 2 * span)) - span), meas);
      default: send_tick(meas + 16'(int'($urandom_range(0, 6000)) - 3000), meas);
    endcase
  endtask

  task automatic test_default_config();
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sd5, -16'sd4);
    send_tick(16'sd10, 16'sd0);
    send_tick(-16'sd10, 16'sd0);
    send_tick(16'sd32767, -16'sd32768);
    send_tick(-16'sd32768, 16'sd32767);
    send_tick(16'sd0, 16'sd0);
  endtask

  task automatic test_gain_and_limit_extremes();
    write_reg(REG_PROP_GAIN, 32'h7FFF_FFFF);
    write_reg(REG_INTEG_GAIN, 32'h0000_0000);
    write_reg(REG_DERIV_GAIN, 32'h8000_0000);
    write_reg(REG_DEAD_BAND, 32'hABCD_0000);
    write_reg(REG_LIMIT_LOW, 32'hFFFF_F000);
    write_reg(REG_LIMIT_HIGH, 32'h0000_0FFF);
    send_tick(16'sd0, 16'sd0);
    send_tick(-16'sd32768, 16'sd32767);
    send_tick(16'sd32767, -16'sd32768);
    write_reg(REG_INTEG_GAIN, 32'h8000_0000);
    send_tick(-16'sd1, 16'sd0);
    write_reg(REG_INTEG_GAIN, 32'h7FFF_FFFF);
    send_tick(16'sd1, 16'sd0);
  endtask

  task automatic test_dead_band_extremes();
    write_reg(REG_DEAD_BAND, 32'h0000_FFFF);
    send_tick(16'sd32767, -16'sd32768);
    send_tick(16'sd100, -16'sd100);
    write_reg(REG_DEAD_BAND, 32'h0000_0001);
    send_tick(16'sd7, 16'sd7);
  endtask

  task automatic test_crossed_limits();
    write_reg(REG_PROP_GAIN, 32'h0001_0000);
    write_reg(REG_INTEG_GAIN, 32'h0000_0000);
    write_reg(REG_DERIV_GAIN, 32'h0000_0000);
    write_reg(REG_LIMIT_LOW, 32'd200);
    write_reg(REG_LIMIT_HIGH, 32'd100);
    send_tick(16'sd150, 16'sd0);
    send_tick(16'sd50, 16'sd0);
    write_reg(REG_LIMIT_HIGH, 32'd0);
    write_reg(REG_LIMIT_LOW, 32'd0);
    send_tick(16'sd300, 16'sd0);
  endtask

  task automatic test_unmapped_index();
    write_reg(REG_UNMAPPED_A, 32'hFFFF_FFFF);
    write_reg(REG_UNMAPPED_B, 32'h1234_5678);
    send_tick(-16'sd40, 16'sd20);
  endtask

  task automatic test_pause_until_drained();
    repeat (12) send_random_tick();
    wait_drain();
    repeat (12) send_random_tick();
  endtask

  task automatic test_random_phases();
    logic [31:0] val;
    for (int ph = 0; ph < 9; ph++) begin
      val = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 1310720) - 655360);
      write_reg(REG_PROP_GAIN, val);
      val = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 262144) - 131072);
      write_reg(REG_INTEG_GAIN, val);
      val = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 1048576) - 524288);
      write_reg(REG_DERIV_GAIN, val);
      val = $urandom;
      if ($urandom_range(0, 5) != 0) val[15:0] = 16'($urandom_range(0, 30));
      write_reg(REG_DEAD_BAND, val);
      val = $urandom;
      if ($urandom_range(0, 4) != 0) val[DRIVE_W-1:0] = 13'd0 - 13'($urandom_range(0, 4095));
      write_reg(REG_LIMIT_LOW, val);
      write_reg(REG_LIMIT_HIGH, $urandom);
      for (int n = 0; n < 118; n++) begin
        if ($urandom_range(0, 59) == 0) wait_drain();
        send_random_tick();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_default_config();
    test_gain_and_limit_extremes();
    test_dead_band_extremes();
    test_crossed_limits();
    test_unmapped_index();
    test_pause_until_drained();
    test_random_phases();
    wait_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && drive_expected_q.size() == 0) begin
      $display("PASS pid_motor_drive_with_deadband_top");
    end else begin
      $display("FAIL pid_motor_drive_with_deadband_top");
    end
    $finish;
  end

endmodule

### filelist.f
src/pmd_pkg.sv
src/pmd_cfg_regs.sv
src/pid_motor_drive_with_deadband_top.sv
sim/pid_motor_drive_with_deadband_top_tb.sv
